@@ src/price_level_book_update_defines.svh @@
// Assertion macros used by the price level book top module.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef PRICE_LEVEL_BOOK_UPDATE_DEFINES_SVH
`define PRICE_LEVEL_BOOK_UPDATE_DEFINES_SVH

// Implication checked on every rising clock edge, disabled in reset.
`define PLB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define PLB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/plbu_pkg.sv @@
// Package for the price level book: widths, function codes, cell control struct.
// No dependencies.
`default_nettype none
package plbu_pkg;
  localparam int DEPTH      = 64;
  localparam int PRICE_BITS = 32;
  localparam int QTY_BITS   = 32;
  localparam int CNT_BITS   = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_UPDATE = 2'd0,
    FUNC_CLEAR_UPDATE = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_SPARE = 2'd3
  } func_t;

  typedef struct packed {
    logic                  we;
    logic                  clear;
    logic                  is_ask;
    logic                  del;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   qty;
  } cell_cmd_t;
endpackage
`default_nettype wire

@@ src/plbu_if.sv @@
// Valid/ready channel carrying a packed payload.
// Depends on nothing; width set by the instantiating scope.
`default_nettype none
interface plbu_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/plbu_cell.sv @@
// One level slot of a sorted side table; shifts with its neighbors on insert/delete.
// Depends on plbu_pkg.
`default_nettype none
module plbu_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  plbu_pkg::cell_cmd_t             cmd,
  input  logic                            ask_side,
  input  logic                            side_hit,
  input  logic                            prev_valid,
  input  logic                            prev_closer,
  input  logic [plbu_pkg::PRICE_BITS-1:0] prev_price,
  input  logic [plbu_pkg::QTY_BITS-1:0]   prev_qty,
  input  logic                            next_valid,
  input  logic [plbu_pkg::PRICE_BITS-1:0] next_price,
  input  logic [plbu_pkg::QTY_BITS-1:0]   next_qty,
  output logic                            valid_o,
  output logic                            closer_o,
  output logic                            match_o,
  output logic [plbu_pkg::PRICE_BITS-1:0] price_o,
  output logic [plbu_pkg::QTY_BITS-1:0]   qty_o
);
  import plbu_pkg::*;
  logic                  valid_r, valid_nxt;
  logic [PRICE_BITS-1:0] price_r, price_nxt;
  logic [QTY_BITS-1:0]   qty_r, qty_nxt;
  logic                  mine;

  // closer: held level sorts ahead of the request price
  assign closer_o = valid_r && (ask_side ? (price_r < cmd.price) : (price_r > cmd.price));
  assign match_o  = valid_r && (price_r == cmd.price);
  assign valid_o  = valid_r;
  assign price_o  = price_r;
  assign qty_o    = qty_r;
  assign mine     = (cmd.is_ask == ask_side) && cmd.we;

  always_comb begin
    valid_nxt = valid_r;
    price_nxt = price_r;
    qty_nxt   = qty_r;
    if (cmd.clear) begin
      valid_nxt = 1'b0;
    end else if (mine) begin
      if (cmd.del) begin
        // on a hit, the matching slot and all slots after it pull up
        if (side_hit && !closer_o) begin
          valid_nxt = next_valid;
          price_nxt = next_price;
          qty_nxt   = next_qty;
        end
      end else if (match_o) begin
        qty_nxt = cmd.qty;
      end else if (!side_hit && !closer_o) begin
        if (prev_closer) begin
          valid_nxt = 1'b1;
          price_nxt = cmd.price;
          qty_nxt   = cmd.qty;
        end else begin
          valid_nxt = prev_valid;
          price_nxt = prev_price;
          qty_nxt   = prev_qty;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    price_r <= price_nxt;
    qty_r   <= qty_nxt;
  end
endmodule
`default_nettype wire

@@ src/plbu_side.sv @@
// Row of level cells for one side plus its count and flags.
// Depends on plbu_pkg and plbu_cell.
`default_nettype none
module plbu_side (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            ask_side,
  input  plbu_pkg::cell_cmd_t             cmd,
  output logic [plbu_pkg::PRICE_BITS-1:0] best_price,
  output logic [plbu_pkg::QTY_BITS-1:0]   best_qty,
  output logic [plbu_pkg::CNT_BITS-1:0]   count,
  output logic                            full,
  output logic                            hit
);
  import plbu_pkg::*;
  logic [DEPTH:0]        v, cl, mt;
  logic [PRICE_BITS-1:0] px [DEPTH+1];
  logic [QTY_BITS-1:0]   qt [DEPTH+1];
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                  mine, ins;

  assign v[DEPTH]  = 1'b0;
  assign cl[DEPTH] = 1'b0;
  assign mt[DEPTH] = 1'b0;
  assign px[DEPTH] = '0;
  assign qt[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  pv, pc;
    logic [PRICE_BITS-1:0] pp;
    logic [QTY_BITS-1:0]   pq;
    if (i == 0) begin : g_head
      assign pv = 1'b0;
      assign pc = 1'b1;
      assign pp = '0;
      assign pq = '0;
    end else begin : g_body
      assign pv = v[i-1];
      assign pc = cl[i-1];
      assign pp = px[i-1];
      assign pq = qt[i-1];
    end
    plbu_cell u_cell (
      .clk, .rst_n, .cmd, .ask_side, .side_hit(hit),
      .prev_valid(pv), .prev_closer(pc), .prev_price(pp), .prev_qty(pq),
      .next_valid(v[i+1]), .next_price(px[i+1]), .next_qty(qt[i+1]),
      .valid_o(v[i]), .closer_o(cl[i]), .match_o(mt[i]),
      .price_o(px[i]), .qty_o(qt[i])
    );
  end

  assign best_price = v[0] ? px[0] : '0;
  assign best_qty   = v[0] ? qt[0] : '0;
  assign count      = cnt_r;
  assign full       = cnt_r == CNT_BITS'(DEPTH);
  assign hit        = |mt;
  assign mine       = cmd.we && (cmd.is_ask == ask_side);
  assign ins        = mine && !cmd.del && !hit;

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.clear) begin
      cnt_nxt = '0;
    end else if (mine && cmd.del && hit) begin
      cnt_nxt = cnt_r - 1'b1;
    end else if (ins && !full) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

@@ src/price_level_book_update.sv @@
// Top level of the price level book: request decode, two cell rows, result register.
// Depends on plbu_pkg, plbu_if, plbu_side and the defines header.
//
// channel  dir  payload
// in_      in   func, is_ask, price, quantity
// out_     out  best bid/ask price and qty, counts, dropped_level, rejected
//
// The cells compare in parallel and shift at the accepting edge; the result register
// loads at the next edge, and input is held meanwhile.
// A clear-and-update request steps through a clear edge, an update edge and the result load.
// Input stalls while a result waits on out_ready.
// rst_n is synchronous; it empties both sides and the result register.
`default_nettype none
`include "price_level_book_update_defines.svh"
module price_level_book_update (
  input  logic clk,
  input  logic rst_n,
  plbu_if.sink   in_ch,
  plbu_if.source out_ch
);
  import plbu_pkg::*;
  localparam int IN_W  = 2 + 1 + PRICE_BITS + QTY_BITS;
  localparam int OUT_W = 2*PRICE_BITS + 2*QTY_BITS + 2*CNT_BITS + 2;

  logic [1:0]            in_func;
  logic                  in_is_ask;
  logic [PRICE_BITS-1:0] in_price;
  logic [QTY_BITS-1:0]   in_quantity;
  logic                  take, clr_stage_r, clr_stage_nxt, out_valid_r;
  logic [IN_W-1:0]       held_r;
  logic [IN_W-1:0]       req;
  cell_cmd_t             cmd;
  logic                  fire_upd;
  logic [PRICE_BITS-1:0] bb_p, ba_p;
  logic [QTY_BITS-1:0]   bb_q, ba_q;
  logic [CNT_BITS-1:0]   bc, ac;
  logic                  bfull, afull, bhit, ahit;
  logic                  side_full, side_hit, dropped, rejected;
  logic [1:0]            flg_r;
  logic [OUT_W-1:0]      out_data_r;
  logic                  pend_r, pend_nxt;

  assign req = clr_stage_r ? held_r : in_ch.data;
  assign {in_func, in_is_ask, in_price, in_quantity} = req;

  assign in_ch.ready = !clr_stage_r && !pend_r && (!out_valid_r || out_ch.ready);
  assign take        = in_ch.valid && in_ch.ready;
  assign clr_stage_nxt = take && (func_t'(in_func) == FUNC_CLEAR_UPDATE);

  always_comb begin
    cmd       = '0;
    cmd.price = in_price;
    cmd.qty   = in_quantity;
    cmd.is_ask = in_is_ask;
    cmd.del   = in_quantity == '0;
    fire_upd  = 1'b0;
    if (clr_stage_r) begin
      fire_upd = 1'b1;
    end else if (take) begin
      unique case (func_t'(in_func))
        FUNC_CLEAR_UPDATE, FUNC_CLEAR: cmd.clear = 1'b1;
        FUNC_UPDATE, FUNC_SPARE:       fire_upd  = 1'b1;
        default:                       cmd.clear = 1'b0;
      endcase
    end
    cmd.we = fire_upd && (in_price != '0);
  end

  plbu_side u_bid (.clk, .rst_n, .ask_side(1'b0), .cmd, .best_price(bb_p),
    .best_qty(bb_q), .count(bc), .full(bfull), .hit(bhit));
  plbu_side u_ask (.clk, .rst_n, .ask_side(1'b1), .cmd, .best_price(ba_p),
    .best_qty(ba_q), .count(ac), .full(afull), .hit(ahit));

  assign side_full = in_is_ask ? afull : bfull;
  assign side_hit  = in_is_ask ? ahit : bhit;
  assign dropped   = cmd.we && !cmd.del && !side_hit && side_full;
  assign rejected  = fire_upd && (in_price == '0);
  assign pend_nxt  = take || clr_stage_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_stage_r <= 1'b0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      clr_stage_r <= clr_stage_nxt;
      pend_r      <= pend_nxt && !clr_stage_nxt;
      if (pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (take) begin
      held_r <= in_ch.data;
    end
    if (pend_nxt) begin
      flg_r <= {dropped, rejected};
    end
    if (pend_r) begin
      out_data_r <= {bb_p, bb_q, ba_p, ba_q, bc, ac, flg_r};
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  `PLB_ASSERT_NEXT(a_clr_stall, clr_stage_r, !clr_stage_r, "clear stage lasted two cycles")
  `PLB_ASSERT_IMP(a_no_take_in_clr, clr_stage_r, !take, "request taken during clear stage")
  `PLB_ASSERT_IMP(a_cnt_bound, 1'b1, bc <= CNT_BITS'(DEPTH) && ac <= CNT_BITS'(DEPTH),
    "level count past depth")
  `PLB_ASSERT_NEXT(a_out_hold, out_valid_r && !out_ch.ready,
    out_valid_r && $stable(out_data_r), "waiting result changed")
endmodule
`default_nettype wire
